// ===== rtl/llid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llid_pkg
// shared widths, codes and the command and status bundles between the
// sequencer and the list datapath
// ----------------------------------------------------------------------------
package llid_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int MAX_RESULTS     = 16;

  localparam int MODE_W  = 2;
  localparam int POS_W   = 8;
  localparam int VAL_W   = 32;
  localparam int ST_W    = 2;
  localparam int COUNT_W = 5;
  localparam int CMP_W   = POS_W + 1;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_FIELD_W = ST_W + VAL_W + COUNT_W;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRAVERSE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic            load_in;
    logic            st_load;
    logic [ST_W-1:0] st_code;
    logic            steps_ins;
    logic            steps_del;
    logic            steps_trav;
    logic            walk_rd;
    logic            pop_rd;
    logic            pop_take;
    logic            alloc_new;
    logic            ins_head;
    logic            ins_w1;
    logic            ins_w2;
    logic            del_w1;
    logic            del_free;
    logic            res_load;
    logic            trav_emit;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              ins_range;
    logic              del_range;
    logic              len_zero;
    logic              pos_zero;
    logic              free_avail;
    logic              steps_one;
    logic              steps_zero;
    logic              out_free;
  } stat_t;

endpackage

// ===== rtl/llid_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llid_ctrl
// sequencer for insert, delete and traverse requests over the linked store
// ----------------------------------------------------------------------------
module llid_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  llid_pkg::stat_t st,
  output llid_pkg::cmd_t  cmd
);
  import llid_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE       = 14'h0001,
    S_DECODE     = 14'h0002,
    S_POP_RD     = 14'h0004,
    S_POP_TAKE   = 14'h0008,
    S_INS_PLACE  = 14'h0010,
    S_INS_WALK   = 14'h0020,
    S_INS_W1     = 14'h0040,
    S_INS_W2     = 14'h0080,
    S_DEL_WALK   = 14'h0100,
    S_DEL_W1     = 14'h0200,
    S_DEL_FREE   = 14'h0400,
    S_TRAV_FIRST = 14'h0800,
    S_TRAV_EMIT  = 14'h1000,
    S_RESULT     = 14'h2000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.mode)
          MODE_INSERT: begin
            if (st.full) begin
              cmd.st_load = 1'b1;
              cmd.st_code = ST_FULL;
              state_nxt   = S_RESULT;
            end else if (st.ins_range) begin
              cmd.st_load = 1'b1;
              cmd.st_code = ST_RANGE;
              state_nxt   = S_RESULT;
            end else begin
              cmd.steps_ins = 1'b1;
              if (st.free_avail) begin
                state_nxt = S_POP_RD;
              end else begin
                cmd.alloc_new = 1'b1;
                state_nxt     = S_INS_PLACE;
              end
            end
          end
          MODE_DELETE: begin
            if (st.len_zero) begin
              cmd.st_load = 1'b1;
              cmd.st_code = ST_EMPTY;
              state_nxt   = S_RESULT;
            end else if (st.del_range) begin
              cmd.st_load = 1'b1;
              cmd.st_code = ST_RANGE;
              state_nxt   = S_RESULT;
            end else begin
              cmd.steps_del = 1'b1;
              state_nxt     = S_DEL_WALK;
            end
          end
          MODE_TRAVERSE: begin
            if (st.len_zero) begin
              cmd.st_load = 1'b1;
              cmd.st_code = ST_EMPTY;
              state_nxt   = S_RESULT;
            end else begin
              cmd.steps_trav = 1'b1;
              state_nxt      = S_TRAV_FIRST;
            end
          end
          default: begin
            cmd.st_load = 1'b1;
            cmd.st_code = ST_OK;
            state_nxt   = S_RESULT;
          end
        endcase
      end
      S_POP_RD: begin
        cmd.pop_rd = 1'b1;
        state_nxt  = S_POP_TAKE;
      end
      S_POP_TAKE: begin
        cmd.pop_take = 1'b1;
        state_nxt    = S_INS_PLACE;
      end
      S_INS_PLACE: begin
        if (st.len_zero || st.pos_zero) begin
          cmd.ins_head = 1'b1;
          cmd.st_load  = 1'b1;
          cmd.st_code  = ST_OK;
          state_nxt    = S_RESULT;
        end else begin
          state_nxt = S_INS_WALK;
        end
      end
      S_INS_WALK: begin
        cmd.walk_rd = 1'b1;
        if (st.steps_one) begin
          state_nxt = S_INS_W1;
        end
      end
      S_INS_W1: begin
        cmd.ins_w1 = 1'b1;
        state_nxt  = S_INS_W2;
      end
      S_INS_W2: begin
        cmd.ins_w2  = 1'b1;
        cmd.st_load = 1'b1;
        cmd.st_code = ST_OK;
        state_nxt   = S_RESULT;
      end
      S_DEL_WALK: begin
        cmd.walk_rd = 1'b1;
        if (st.steps_one) begin
          state_nxt = st.pos_zero ? S_DEL_FREE : S_DEL_W1;
        end
      end
      S_DEL_W1: begin
        cmd.del_w1 = 1'b1;
        state_nxt  = S_DEL_FREE;
      end
      S_DEL_FREE: begin
        cmd.del_free = 1'b1;
        cmd.st_load  = 1'b1;
        cmd.st_code  = ST_OK;
        state_nxt    = S_RESULT;
      end
      S_TRAV_FIRST: begin
        cmd.walk_rd = 1'b1;
        state_nxt   = S_TRAV_EMIT;
      end
      S_TRAV_EMIT: begin
        if (st.out_free) begin
          cmd.trav_emit = 1'b1;
          if (st.steps_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.walk_rd = 1'b1;
          end
        end
      end
      S_RESULT: begin
        if (st.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/llid_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llid_dp
// entry and link memories, free list, list registers and result register
// ----------------------------------------------------------------------------
module llid_dp #(
  parameter int MAX_ENTRIES = llid_pkg::MAX_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [llid_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  llid_pkg::cmd_t                   cmd,
  output llid_pkg::stat_t                  st,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [llid_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast
);
  import llid_pkg::*;

  localparam int SW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;

  logic [VAL_W-1:0] entry_mem [MAX_ENTRIES];
  logic [SW-1:0]    link_mem  [MAX_ENTRIES];

  logic [MODE_W-1:0] mode_r;
  logic [POS_W-1:0]  pos_r;
  logic [VAL_W-1:0]  val_r;
  logic [ST_W-1:0]   st_r;

  logic [CW-1:0] len_r;
  logic [CW-1:0] hwm_r;
  logic [SW-1:0] head_r;
  logic [SW-1:0] fhead_r;
  logic [SW-1:0] ns_r;
  logic [SW-1:0] addr1_r;
  logic [SW-1:0] addr2_r;
  logic [NW-1:0] steps_r;
  logic          first_r;

  logic [SW-1:0]    link_q_r;
  logic [VAL_W-1:0] entry_q_r;

  logic               out_valid_r;
  logic [ST_W-1:0]    out_st_r;
  logic [VAL_W-1:0]   out_val_r;
  logic               out_last_r;
  logic [COUNT_W-1:0] out_cnt_r;

  logic             out_free;
  logic [SW-1:0]    walk_addr;
  logic             link_re;
  logic [SW-1:0]    link_raddr;
  logic             link_we;
  logic [SW-1:0]    link_waddr;
  logic [SW-1:0]    link_wdata;
  logic             entry_we;
  logic [NW-1:0]    trav_n;

  assign out_free  = !out_valid_r || out_tready;
  assign walk_addr = first_r ? head_r : link_q_r;
  assign trav_n    = (CMP_W'(len_r) > CMP_W'(MAX_RESULTS)) ? NW'(MAX_RESULTS) : NW'(len_r);

  always_comb begin
    st            = '0;
    st.mode       = mode_r;
    st.full       = CMP_W'(len_r) >= CMP_W'(MAX_ENTRIES);
    st.len_zero   = (len_r == '0);
    st.pos_zero   = (pos_r == '0);
    st.ins_range  = !st.len_zero && (CMP_W'(pos_r) > CMP_W'(len_r));
    st.del_range  = CMP_W'(pos_r) >= CMP_W'(len_r);
    st.free_avail = (hwm_r != len_r);
    st.steps_one  = (steps_r == NW'(1));
    st.steps_zero = (steps_r == '0);
    st.out_free   = out_free;
  end

  // link memory port selection
  always_comb begin
    link_re    = cmd.walk_rd || cmd.pop_rd;
    link_raddr = cmd.pop_rd ? fhead_r : walk_addr;
    link_we    = 1'b0;
    link_waddr = ns_r;
    link_wdata = head_r;
    if (cmd.ins_head) begin
      link_we    = 1'b1;
      link_waddr = ns_r;
      link_wdata = head_r;
    end else if (cmd.ins_w1) begin
      link_we    = 1'b1;
      link_waddr = ns_r;
      link_wdata = link_q_r;
    end else if (cmd.ins_w2) begin
      link_we    = 1'b1;
      link_waddr = addr1_r;
      link_wdata = ns_r;
    end else if (cmd.del_w1) begin
      link_we    = 1'b1;
      link_waddr = addr2_r;
      link_wdata = link_q_r;
    end else if (cmd.del_free) begin
      link_we    = 1'b1;
      link_waddr = addr1_r;
      link_wdata = fhead_r;
    end
  end

  assign entry_we = cmd.ins_head || cmd.ins_w1;

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_q_r <= link_mem[link_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (entry_we) begin
      entry_mem[ns_r] <= val_r;
    end
    if (cmd.walk_rd) begin
      entry_q_r <= entry_mem[walk_addr];
    end
  end

  // request fields and walk bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= in_tdata[MODE_W-1:0];
      pos_r  <= in_tdata[MODE_W +: POS_W];
      val_r  <= in_tdata[MODE_W+POS_W +: VAL_W];
    end
    if (cmd.st_load) begin
      st_r <= cmd.st_code;
    end
    if (cmd.alloc_new) begin
      ns_r <= SW'(hwm_r);
    end else if (cmd.pop_take) begin
      ns_r <= fhead_r;
    end
    if (cmd.steps_ins) begin
      steps_r <= NW'(pos_r);
      first_r <= 1'b1;
    end else if (cmd.steps_del) begin
      steps_r <= NW'(pos_r) + NW'(1);
      first_r <= 1'b1;
    end else if (cmd.steps_trav) begin
      steps_r <= trav_n;
      first_r <= 1'b1;
    end else if (cmd.walk_rd) begin
      steps_r <= steps_r - NW'(1);
      first_r <= 1'b0;
      addr1_r <= walk_addr;
      addr2_r <= addr1_r;
    end
  end

  // list registers and free list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      hwm_r   <= '0;
      head_r  <= '0;
      fhead_r <= '0;
    end else begin
      if (cmd.alloc_new) begin
        hwm_r <= hwm_r + CW'(1);
      end
      if (cmd.pop_take) begin
        fhead_r <= link_q_r;
      end else if (cmd.del_free) begin
        fhead_r <= addr1_r;
      end
      if (cmd.ins_head) begin
        head_r <= ns_r;
      end else if (cmd.del_free && (pos_r == '0)) begin
        head_r <= link_q_r;
      end
      if (cmd.ins_head || cmd.ins_w2) begin
        len_r <= len_r + CW'(1);
      end else if (cmd.del_free) begin
        len_r <= len_r - CW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load || cmd.trav_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_st_r   <= st_r;
      out_val_r  <= '0;
      out_last_r <= 1'b1;
      out_cnt_r  <= COUNT_W'(len_r);
    end else if (cmd.trav_emit) begin
      out_st_r   <= ST_OK;
      out_val_r  <= entry_q_r;
      out_last_r <= (steps_r == '0);
      out_cnt_r  <= COUNT_W'(len_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_cnt_r, out_val_r, out_st_r};

`ifndef ASSERT_OFF
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(len_r) <= CMP_W'(MAX_ENTRIES))
    else $error("list length beyond store size");

  a_hwm_cover: assert property (@(posedge clk) disable iff (!rst_n)
    hwm_r >= len_r)
    else $error("slots in use exceed slots ever allocated");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res_load || cmd.trav_emit) |-> out_free)
    else $error("result register overwritten while held");

  a_walk_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.walk_rd && !first_r) |-> (steps_r != '0))
    else $error("link walk past its step count");
`endif

endmodule

// ===== rtl/linked_list_insert_delete_at_index_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_list_insert_delete_at_index_unit
// bounded ordered list of signed 32-bit values held as linked slots
// ----------------------------------------------------------------------------
// in_*  : one request beat, in_tdata = mode, position, value (low bits first)
//         mode 0 inserts before position, 1 deletes at position, 2 traverses
// out_* : result beats, out_tdata = status, entry_value, entry_count;
//         out_tlast marks the final result of a request
// insert and delete give one beat, traverse one beat per entry (up to 16)
// or a single empty beat; errors (full, out of range, empty) change nothing
// an insert takes a freed slot from the free list or else a new slot, then links
// it in at the head, or walks the links to its position and writes the new slot's
// link and then its predecessor's; a delete walks to its position, relinks the
// predecessor unless at the head and returns the slot to the free list; a traverse
// reads the head, then loads a beat per entry; errors and the spare mode give the status
// beat directly; walks read one link per cycle, stalled in traverse by a held result
// the next request is taken in the cycle after the final beat is loaded
// one request at a time; in_tready is high only between requests
// a held result stalls the next result load until out_tready takes it
// reset empties the list at once; no clearing pass is needed
// ----------------------------------------------------------------------------
module linked_list_insert_delete_at_index_unit #(
  parameter int MAX_ENTRIES = llid_pkg::MAX_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [llid_pkg::IN_TDATA_W-1:0]  in_tdata,   // mode, position, value
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [llid_pkg::OUT_TDATA_W-1:0] out_tdata,  // status, entry_value, entry_count
  output logic                             out_tlast
);
  import llid_pkg::*;

  cmd_t  cmd;
  stat_t st;

  llid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  llid_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
